FILE: rtl/core/pht_pkg.sv
// Shared types, codes and constants of the pad hit map table.
package pht_pkg;

  // Default sizes of the table and of the stored digit magnitude.
  localparam int unsigned TableDepthDef = 32768;
  localparam int unsigned DigitBitsDef  = 16;

  // Fixed field widths.
  localparam int unsigned CfgW   = 7;
  localparam int unsigned CoordW = 8;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned DigitW = 16;
  localparam int unsigned HitW   = 17;
  // Signed raw cell address and unsigned table limit.
  localparam int unsigned RawW   = 18;
  localparam int unsigned LimW   = 17;

  typedef enum logic [CmdW-1:0] {
    CMD_SET    = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_FLAG   = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_EMPTY  = 2'd0,
    STAT_UNUSED = 2'd1,
    STAT_USED   = 2'd2
  } status_e;

  typedef enum logic {
    REG_HALF_COLS = 1'b0,
    REG_HALF_ROWS = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_e;

  // Access request to the cell memory.
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_cmd_t;

  // Status of the current item's address.
  typedef struct packed {
    logic neg;
    logic in_range;
  } addr_info_t;

endpackage

FILE: rtl/core/pht_addr.sv
// Configuration registers, table limit and cell address generation.
module pht_addr import pht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  input  logic                     load_i,
  input  logic signed [CoordW-1:0] pad_x_i,
  input  logic signed [CoordW-1:0] pad_y_i,
  output addr_info_t               info_o,
  output logic [AW-1:0]            cell_addr_o
);

  localparam logic [LimW-1:0] DepthL = LimW'(TABLE_DEPTH);

  logic [CfgW-1:0]        hc_q, hr_q;
  logic [15:0]            area;
  logic [LimW-1:0]        limit_full, limit_d, limit_q;
  logic signed [9:0]      xs, rows2, ys;
  logic signed [19:0]     prod;
  logic signed [RawW-1:0] raw_d, raw_q;
  logic [CoordW-1:0]      ax, ay;
  logic                   inr_d, inr_q;
  logic                   at_limit;
  logic [LimW-1:0]        sel;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= CfgW'(1);
      hr_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HALF_COLS: hc_q <= cfg_data_i;
        REG_HALF_ROWS: hr_q <= cfg_data_i;
      endcase
    end
  end

  // Table limit 4*(hc+1)*(hr+1) + 2*hr, capped at the table depth.
  assign area       = (16'(hc_q) + 16'd1) * (16'(hr_q) + 16'd1);
  assign limit_full = LimW'({area, 2'b00}) + LimW'({hr_q, 1'b0});
  assign limit_d    = (limit_full > DepthL) ? DepthL : limit_full;

  always_ff @(posedge clk_i) begin
    limit_q <= limit_d;
  end

  // Raw address 2*hr*(x+hc) + (y+hr); neighboring rows alias on purpose.
  assign xs    = $signed({{2{pad_x_i[CoordW-1]}}, pad_x_i}) + $signed({3'b000, hc_q});
  assign rows2 = $signed({2'b00, hr_q, 1'b0});
  assign prod  = 20'(xs) * 20'(rows2);
  assign ys    = $signed({{2{pad_y_i[CoordW-1]}}, pad_y_i}) + $signed({3'b000, hr_q});
  assign raw_d = RawW'(prod) + RawW'(ys);

  // Coordinate bounds check.
  assign ax    = pad_x_i[CoordW-1] ? (~pad_x_i + 8'd1) : pad_x_i;
  assign ay    = pad_y_i[CoordW-1] ? (~pad_y_i + 8'd1) : pad_y_i;
  assign inr_d = (ax <= {1'b0, hc_q}) && (ay <= {1'b0, hr_q});

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      raw_q <= raw_d;
      inr_q <= inr_d;
    end
  end

  // Clamp to the last cell below the limit.
  assign at_limit    = raw_q >= $signed({1'b0, limit_q});
  assign sel         = at_limit ? (limit_q - LimW'(1)) : raw_q[LimW-1:0];
  assign cell_addr_o = sel[AW-1:0];

  assign info_o.neg      = raw_q[RawW-1];
  assign info_o.in_range = inr_q;

endmodule

FILE: rtl/core/pht_ram.sv
// Single-port synchronous cell memory with registered read data.
module pht_ram import pht_pkg::*; #(
  parameter int unsigned DEPTH = TableDepthDef,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned WW    = DigitBitsDef + 1
) (
  input  logic          clk_i,
  input  mem_cmd_t      cmd_i,
  input  logic [AW-1:0] addr_i,
  input  logic [WW-1:0] wdata_i,
  output logic [WW-1:0] rdata_o
);

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rdata_q;

  // Write and read both use the shared address.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[addr_i] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pht_ctrl.sv
// Command sequencer: clear sweep, read-modify-write of one cell and result.
module pht_ctrl import pht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned DIGIT_BITS  = DigitBitsDef,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH),
  parameter int unsigned WW          = DIGIT_BITS + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [CmdW-1:0]        command_i,
  input  logic [DigitW-1:0]      digit_index_i,
  output logic                   load_o,
  input  addr_info_t             info_i,
  input  logic [AW-1:0]          cell_addr_i,
  output mem_cmd_t               mem_cmd_o,
  output logic [AW-1:0]          mem_addr_o,
  output logic [WW-1:0]          mem_wdata_o,
  input  logic [WW-1:0]          mem_rdata_i,
  output logic                   result_valid_o,
  output logic [1:0]             cell_status_o,
  output logic signed [HitW-1:0] hit_index_o,
  output logic                   in_range_o
);

  localparam logic [AW-1:0] LastAddr = AW'(TABLE_DEPTH - 1);
  localparam logic [32:0]   DigitMax = (33'd1 << DIGIT_BITS) - 33'd2;
  localparam int unsigned   XW       = (DIGIT_BITS > HitW) ? DIGIT_BITS : HitW;

  state_e                state_q, state_d;
  logic [AW-1:0]         cnt_q, cnt_d;
  logic                  pend_q, pend_d;
  cmd_e                  cmd_q, cmd_dec;
  logic [DIGIT_BITS-1:0] mag_set_q, mag_set_d;
  logic [32:0]           digit_ext, digit_sat;
  logic [WW-1:0]         new_word;
  logic [DIGIT_BITS-1:0] new_mag;
  logic [XW-1:0]         mag_x;
  logic                  emit, emit_clear;
  logic                  valid_q;
  status_e               status_q, status_d;
  logic [HitW-1:0]       hit_q, hit_d;
  logic                  inr_q;

  // Unknown command codes act as a query.
  assign cmd_dec = (command_i <= CMD_CLEAR) ? cmd_e'(command_i) : CMD_QUERY;

  // Saturate the digit so that digit+1 fits the stored magnitude.
  assign digit_ext = 33'(digit_index_i);
  assign digit_sat = (digit_ext > DigitMax) ? DigitMax : digit_ext;
  assign mag_set_d = DIGIT_BITS'(digit_sat + 33'd1);

  // New cell word from the command and the word read back; zero for a negative address.
  always_comb begin
    new_word = mem_rdata_i;
    unique case (cmd_q)
      CMD_SET:    new_word = {1'b0, mag_set_q};
      CMD_DELETE: new_word = '0;
      CMD_FLAG:   new_word = {1'b1, mem_rdata_i[DIGIT_BITS-1:0]};
      default:    new_word = mem_rdata_i;
    endcase
    if (info_i.neg) begin
      new_word = '0;
    end
  end

  assign new_mag = new_word[DIGIT_BITS-1:0];
  assign mag_x   = XW'(new_mag);

  // Sequencer: next state, memory access and result load.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    load_o      = 1'b0;
    mem_cmd_o   = '0;
    mem_addr_o  = cell_addr_i;
    mem_wdata_o = new_word;
    emit        = 1'b0;
    emit_clear  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_cmd_o.wr = 1'b1;
        mem_addr_o   = cnt_q;
        mem_wdata_o  = '0;
        cnt_d        = cnt_q + AW'(1);
        if (pend_q) begin
          emit       = 1'b1;
          emit_clear = 1'b1;
          pend_d     = 1'b0;
        end
        if (cnt_q == LastAddr) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          load_o = 1'b1;
          if (cmd_dec == CMD_CLEAR) begin
            pend_d  = 1'b1;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        mem_cmd_o.rd = !info_i.neg;
        state_d      = ST_WRITE;
      end
      ST_WRITE: begin
        mem_cmd_o.wr = !info_i.neg;
        emit         = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result fields of the cell after the command.
  always_comb begin
    if (emit_clear || new_mag == '0) begin
      status_d = STAT_EMPTY;
      hit_d    = '1;
    end else begin
      status_d = new_word[WW-1] ? STAT_USED : STAT_UNUSED;
      hit_d    = mag_x[HitW-1:0] - HitW'(1);
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      valid_q <= emit;
    end
  end

  // Captured command and result payload.
  always_ff @(posedge clk_i) begin
    if (load_o) begin
      cmd_q     <= cmd_dec;
      mag_set_q <= mag_set_d;
    end
    if (emit) begin
      status_q <= status_d;
      hit_q    <= hit_d;
      inr_q    <= info_i.in_range;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign cell_status_o  = status_q;
  assign hit_index_o    = $signed(hit_q);
  assign in_range_o     = inr_q;

endmodule

FILE: rtl/core/pad_hit_map_table.sv
// Top level of the pad hit map table.
// A command is accepted when start is high and busy is low. Set, delete, flag
// and query pass through the accept cycle, which computes the cell address,
// the read state, which reads the single-port cell memory, and the write state,
// which writes the new word back; the result strobe result_valid_o rises for
// one cycle right after that, and a new command may be accepted in that same
// cycle. A clear command's result strobe is registered from the first cycle of
// its sweep, and busy stays high while the sweep zeroes all TABLE_DEPTH cells
// (32768 by default), one cell per cycle; the same sweep runs after reset
// before the first command is taken. Configuration writes are for the user to
// make only while the block is idle; the block does not enforce this. Results
// cannot be held off: the receiver must take each one in the cycle it is shown.
module pad_hit_map_table import pht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned DIGIT_BITS  = DigitBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  input  logic                     start,
  output logic                     busy,
  input  logic [CmdW-1:0]          command_i,
  input  logic signed [CoordW-1:0] pad_x_i,
  input  logic signed [CoordW-1:0] pad_y_i,
  input  logic [DigitW-1:0]        digit_index_i,
  output logic                     result_valid_o,
  output logic [1:0]               cell_status_o,
  output logic signed [HitW-1:0]   hit_index_o,
  output logic                     in_range_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned WW = DIGIT_BITS + 1;

  logic          load;
  addr_info_t    info;
  logic [AW-1:0] cell_addr;
  mem_cmd_t      mem_cmd;
  logic [AW-1:0] mem_addr;
  logic [WW-1:0] mem_wdata, mem_rdata;

  // Address generation and configuration.
  pht_addr #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_addr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .load_i      (load),
    .pad_x_i     (pad_x_i),
    .pad_y_i     (pad_y_i),
    .info_o      (info),
    .cell_addr_o (cell_addr)
  );

  // Command sequencer.
  pht_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DIGIT_BITS  (DIGIT_BITS),
    .AW          (AW),
    .WW          (WW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .digit_index_i  (digit_index_i),
    .load_o         (load),
    .info_i         (info),
    .cell_addr_i    (cell_addr),
    .mem_cmd_o      (mem_cmd),
    .mem_addr_o     (mem_addr),
    .mem_wdata_o    (mem_wdata),
    .mem_rdata_i    (mem_rdata),
    .result_valid_o (result_valid_o),
    .cell_status_o  (cell_status_o),
    .hit_index_o    (hit_index_o),
    .in_range_o     (in_range_o)
  );

  // Cell memory.
  pht_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .WW    (WW)
  ) u_ram (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: rtl/core/pht_checker.sv
// Port-level checks of the pad hit map table and their binding.
module pht_checker import pht_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic                   result_valid_o,
  input logic [1:0]             cell_status_o,
  input logic signed [HitW-1:0] hit_index_o
);

  // An accepted command always makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted item");

  // The result strobe is single-cycle; results never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // An empty cell reports hit index minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && cell_status_o == STAT_EMPTY) |-> (hit_index_o == -1))
    else $error("empty cell with a hit index");

  // The status code is always a defined one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (cell_status_o == STAT_EMPTY || cell_status_o == STAT_UNUSED ||
                        cell_status_o == STAT_USED))
    else $error("undefined cell status");

endmodule

bind pad_hit_map_table pht_checker u_pht_checker (.*);
